/* rtl/fsdec_pkg.sv */
`default_nettype none

package fsdec_pkg;

    localparam int N_COEFF   = 512;
    localparam int MAX_BYTES = 1024;
    localparam int MODQ      = 12289;
    localparam int RUN_LIMIT = 97;

    localparam int BYTE_W   = 8;
    localparam int VALUE_W  = 14;
    localparam int IDX_W    = 9;
    localparam int STATUS_W = 3;
    localparam int LOW_W    = 7;
    localparam int RUN_W    = 7;
    localparam int LCNT_W   = 3;
    localparam int CNT_W    = $clog2(N_COEFF + 1);
    localparam int BCNT_W   = $clog2(MAX_BYTES + 1);

    typedef enum logic [1:0] {
        PH_SIGN,
        PH_LOW,
        PH_HIGH,
        PH_DONE
    } phase_t;

    typedef enum logic [STATUS_W-1:0] {
        ST_OK,
        ST_MAG,
        ST_SHORT,
        ST_TRAIL,
        ST_LONG
    } status_t;

    typedef struct packed {
        phase_t             phase;
        logic [LCNT_W-1:0]  lcnt;
        logic               sign;
        logic [LOW_W-1:0]   low;
        logic [RUN_W-1:0]   zrun;
        logic [CNT_W-1:0]   cnt;
        status_t            err;
    } dec_state_t;

    typedef struct packed {
        logic               hit;
        logic               sign;
        logic [VALUE_W-1:0] mag;
        logic [IDX_W-1:0]   idx;
    } bit_hit_t;

    typedef struct packed {
        logic                coef_valid;
        logic [VALUE_W-1:0]  coef_value;
        logic [IDX_W-1:0]    coef_index;
        logic                stream_done;
        logic [STATUS_W-1:0] status;
    } res_t;

    localparam dec_state_t DEC_RESET = '{
        phase: PH_SIGN,
        lcnt:  '0,
        sign:  1'b0,
        low:   '0,
        zrun:  '0,
        cnt:   '0,
        err:   ST_OK
    };

endpackage

`default_nettype wire

/* rtl/fsdec_in_if.sv */
`default_nettype none

interface fsdec_in_if;
    import fsdec_pkg::*;

    logic              valid;
    logic              ready;
    logic [BYTE_W-1:0] data_byte;
    logic              last_byte;

    modport source (output valid, output data_byte, output last_byte, input ready);
    modport sink (input valid, input data_byte, input last_byte, output ready);
endinterface

`default_nettype wire

/* rtl/fsdec_out_if.sv */
`default_nettype none

interface fsdec_out_if;
    import fsdec_pkg::*;

    logic                valid;
    logic                ready;
    logic                coef_valid;
    logic [VALUE_W-1:0]  coef_value;
    logic [IDX_W-1:0]    coef_index;
    logic                stream_done;
    logic [STATUS_W-1:0] status;

    modport source (
        output valid, output coef_valid, output coef_value, output coef_index,
        output stream_done, output status, input ready
    );
    modport sink (
        input valid, input coef_valid, input coef_value, input coef_index,
        input stream_done, input status, output ready
    );
endinterface

`default_nettype wire

/* rtl/fsdec_bit.sv */
`default_nettype none

module fsdec_bit (
    input  fsdec_pkg::dec_state_t st,
    input  logic                  bit_in,
    output fsdec_pkg::dec_state_t st_next,
    output fsdec_pkg::bit_hit_t   hit
);
    import fsdec_pkg::*;

    logic [VALUE_W-1:0] mag;
    logic               too_big;
    logic [RUN_W-1:0]   zrun_inc;
    logic [CNT_W-1:0]   cnt_inc;

    assign mag      = {st.zrun, st.low};
    assign too_big  = mag >= VALUE_W'(MODQ);
    assign zrun_inc = st.zrun + RUN_W'(1);
    assign cnt_inc  = st.cnt + CNT_W'(1);

    always_comb
    begin
        st_next = st;
        if (st.err == ST_OK)
        begin
            unique case (st.phase)
                PH_SIGN:
                begin
                    st_next.sign  = bit_in;
                    st_next.low   = '0;
                    st_next.lcnt  = '0;
                    st_next.zrun  = '0;
                    st_next.phase = PH_LOW;
                end
                PH_LOW:
                begin
                    st_next.low  = {st.low[LOW_W-2:0], bit_in};
                    st_next.lcnt = st.lcnt + LCNT_W'(1);
                    if (st.lcnt + LCNT_W'(1) == LCNT_W'(LOW_W))
                    begin
                        st_next.phase = PH_HIGH;
                    end
                end
                PH_HIGH:
                begin
                    if (!bit_in)
                    begin
                        // a run this long can only give an oversized magnitude
                        if (zrun_inc >= RUN_W'(RUN_LIMIT))
                        begin
                            st_next.zrun = RUN_W'(RUN_LIMIT);
                            st_next.err  = ST_MAG;
                        end
                        else
                        begin
                            st_next.zrun = zrun_inc;
                        end
                    end
                    else if (too_big)
                    begin
                        st_next.err = ST_MAG;
                    end
                    else
                    begin
                        st_next.cnt   = cnt_inc;
                        st_next.phase = (cnt_inc >= CNT_W'(N_COEFF)) ? PH_DONE : PH_SIGN;
                    end
                end
                PH_DONE:
                begin
                    if (bit_in)
                    begin
                        st_next.err = ST_TRAIL;
                    end
                end
                default:
                begin
                    st_next = st;
                end
            endcase
        end
    end

    always_comb
    begin
        hit.hit  = (st.err == ST_OK) && (st.phase == PH_HIGH) && bit_in && !too_big;
        hit.sign = st.sign;
        hit.mag  = mag;
        hit.idx  = IDX_W'(st.cnt);
    end

endmodule

`default_nettype wire

/* rtl/fsdec_core.sv */
`default_nettype none

module fsdec_core (
    input  logic              clk,
    input  logic              rst_n,
    fsdec_in_if.sink          byte_ch,
    input  logic              room,
    output logic              push,
    output fsdec_pkg::res_t   res
);
    import fsdec_pkg::*;

    dec_state_t        state_reg;
    dec_state_t        state_next;
    logic [BCNT_W-1:0] bcnt_reg;
    logic [BCNT_W-1:0] bcnt_next;

    dec_state_t        pre;
    dec_state_t        post;
    dec_state_t        chain [0:BYTE_W];
    bit_hit_t          hits  [0:BYTE_W-1];

    logic               any_hit;
    logic               sel_sign;
    logic [VALUE_W-1:0] sel_mag;
    logic [IDX_W-1:0]   sel_idx;

    assign byte_ch.ready = room;
    assign push          = byte_ch.valid && room;

    always_comb
    begin
        pre       = state_reg;
        bcnt_next = bcnt_reg;
        if (state_reg.err == ST_OK)
        begin
            if (bcnt_reg >= BCNT_W'(MAX_BYTES))
            begin
                pre.err = ST_LONG;
            end
            else
            begin
                bcnt_next = bcnt_reg + BCNT_W'(1);
            end
        end
    end

    assign chain[0] = pre;

    for (genvar g = 0; g < BYTE_W; g++)
    begin : g_bit
        fsdec_bit u_bit (
            .st      (chain[g]),
            .bit_in  (byte_ch.data_byte[BYTE_W-1-g]),
            .st_next (chain[g+1]),
            .hit     (hits[g])
        );
    end

    // a coefficient spans at least nine bits, so at most one lane hits
    always_comb
    begin
        any_hit  = 1'b0;
        sel_sign = 1'b0;
        sel_mag  = '0;
        sel_idx  = '0;
        for (int i = 0; i < BYTE_W; i++)
        begin
            any_hit  = any_hit | hits[i].hit;
            sel_sign = sel_sign | (hits[i].hit & hits[i].sign);
            sel_mag  = sel_mag | (hits[i].mag & {VALUE_W{hits[i].hit}});
            sel_idx  = sel_idx | (hits[i].idx & {IDX_W{hits[i].hit}});
        end
    end

    always_comb
    begin
        post = chain[BYTE_W];
        if (byte_ch.last_byte && post.err == ST_OK && post.cnt < CNT_W'(N_COEFF))
        begin
            post.err = ST_SHORT;
        end
    end

    always_comb
    begin
        res.coef_valid  = any_hit;
        res.coef_value  = (sel_sign && sel_mag != '0) ? VALUE_W'(MODQ) - sel_mag : sel_mag;
        res.coef_index  = sel_idx;
        res.stream_done = byte_ch.last_byte;
        res.status      = post.err;
    end

    assign state_next = byte_ch.last_byte ? DEC_RESET : post;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= DEC_RESET;
            bcnt_reg  <= '0;
        end
        else if (push)
        begin
            state_reg <= state_next;
            bcnt_reg  <= byte_ch.last_byte ? '0 : bcnt_next;
        end
    end

`ifndef SYNTHESIS
    a_cnt_range: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg.cnt <= CNT_W'(N_COEFF))
        else $error("coefficient count past polynomial size");

    a_err_sticky: assert property (@(posedge clk) disable iff (!rst_n)
        push && state_reg.err != ST_OK && !byte_ch.last_byte
        |=> state_reg.err == $past(state_reg.err))
        else $error("error code changed within a stream");

    a_value_range: assert property (@(posedge clk) disable iff (!rst_n)
        push && res.coef_valid |-> res.coef_value < VALUE_W'(MODQ))
        else $error("coefficient value not reduced");
`endif

endmodule

`default_nettype wire

/* rtl/fsdec_out.sv */
`default_nettype none

module fsdec_out (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              push,
    input  fsdec_pkg::res_t   din,
    output logic              room,
    fsdec_out_if.source       coef_ch
);
    import fsdec_pkg::*;

    res_t       ent0_reg;
    res_t       ent1_reg;
    res_t       ent0_next;
    res_t       ent1_next;
    logic [1:0] count_reg;
    logic [1:0] count_next;
    logic       pop;

    assign room = (count_reg != 2'd2);
    assign pop  = coef_ch.valid && coef_ch.ready;

    always_comb
    begin
        ent0_next  = ent0_reg;
        ent1_next  = ent1_reg;
        count_next = count_reg + 2'(push) - 2'(pop);
        unique case (count_reg)
            2'd0:
            begin
                if (push)
                begin
                    ent0_next = din;
                end
            end
            2'd1:
            begin
                if (push && pop)
                begin
                    ent0_next = din;
                end
                else if (push)
                begin
                    ent1_next = din;
                end
            end
            2'd2:
            begin
                // advance the skid beat into the head
                if (pop)
                begin
                    ent0_next = ent1_reg;
                end
            end
            default:
            begin
                count_next = count_reg;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg <= '0;
        end
        else
        begin
            count_reg <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        ent0_reg <= ent0_next;
        ent1_reg <= ent1_next;
    end

    assign coef_ch.valid       = (count_reg != 2'd0);
    assign coef_ch.coef_valid  = ent0_reg.coef_valid;
    assign coef_ch.coef_value  = ent0_reg.coef_value;
    assign coef_ch.coef_index  = ent0_reg.coef_index;
    assign coef_ch.stream_done = ent0_reg.stream_done;
    assign coef_ch.status      = ent0_reg.status;

`ifndef SYNTHESIS
    a_count_range: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg != 2'd3)
        else $error("output queue overflow");

    a_drain: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg == 2'd1 && pop && !push |=> !coef_ch.valid)
        else $error("output valid after last beat drained");
`endif

endmodule

`default_nettype wire

/* rtl/falcon_sig_coeff_decoder_top.sv */
// Signature coefficient decompressor.
// byte_ch (sink) takes one beat per stream byte: data_byte, MSB first, and
// last_byte on the final byte of a signature. coef_ch (source) returns exactly
// one beat per byte: coef_valid/coef_value/coef_index for a coefficient that
// ended in that byte, stream_done echoing last_byte, and the running status.
// Each result beat is registered in the output queue before it appears on coef_ch.
// Throughput: one byte per cycle while the output queue has room; all eight
// bits of a byte are decoded by one pass of combinational logic between the
// input handshake and the two-entry output queue.
// Stall: when coef_ch is not ready the queue holds up to two result beats;
// byte_ch.ready drops only while both entries are full.
// Errors are sticky until the last byte; the beat for the last byte carries
// the final status and the decoder then returns to its reset state.
// Reset clears the decoder state and empties the output queue; no result is
// pending after reset.
`default_nettype none

module falcon_sig_coeff_decoder_top (
    input  logic         clk,
    input  logic         rst_n,
    fsdec_in_if.sink     byte_ch,
    fsdec_out_if.source  coef_ch
);
    import fsdec_pkg::*;

    logic room;
    logic push;
    res_t res;

    fsdec_core u_core (
        .clk     (clk),
        .rst_n   (rst_n),
        .byte_ch (byte_ch),
        .room    (room),
        .push    (push),
        .res     (res)
    );

    fsdec_out u_out (
        .clk     (clk),
        .rst_n   (rst_n),
        .push    (push),
        .din     (res),
        .room    (room),
        .coef_ch (coef_ch)
    );

endmodule

`default_nettype wire
